>>> src/mfdu_pkg.sv
// Shared types and constants for the motor feedback frame decoder.
// Used by mfdu_unwrap and motor_feedback_frame_decode_unwrap; no dependencies.
`default_nettype none

package mfdu_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned VEL_W       = 12;
  localparam int unsigned COUNT_W     = 48;
  localparam int unsigned DELTA_W     = POS_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MASTER_ID      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_NUM      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_DEADBAND = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_POSITION  = 2'd3;

  // Register reset values.
  localparam logic [10:0]      MASTER_ID_RST      = 11'd0;
  localparam logic [3:0]       MOTOR_NUM_RST      = 4'd1;
  localparam logic [11:0]      SPEED_DEADBAND_RST = 12'd6;
  localparam logic [POS_W-1:0] INIT_POSITION_RST  = 16'd32768;

  // One turn of the position code, and the velocity code at standstill times two.
  localparam logic signed [DELTA_W-1:0] TURN_COUNTS = 17'sd65535;
  localparam logic signed [DELTA_W-1:0] HALF_TURN   = 17'sd32768;
  localparam logic signed [VEL_W:0]     VEL_ZERO_X2 = 13'sd4095;

  typedef struct packed {
    logic [10:0] can_id;
    logic [63:0] frame_payload;
  } frame_t;

  typedef struct packed {
    logic [POS_W-1:0]          position_code;
    logic [VEL_W-1:0]          velocity_code;
    logic [11:0]               torque_code;
    logic [3:0]                motor_state;
    logic                      fault_flag;
    logic [7:0]                driver_temp;
    logic [7:0]                rotor_temp;
    logic signed [COUNT_W-1:0] turn_count_position;
  } result_t;

  // One position sample handed to the unwrap stage.
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [VEL_W-1:0] vel;
  } unwrap_step_t;

  // Calibration load of the unwrap state.
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] value;
  } unwrap_load_t;

endpackage

`default_nettype wire

>>> src/mfdu_unwrap.sv
// Multi-turn position unwrap: holds the last position code and the 48-bit count.
// Depends on mfdu_pkg for widths, constants and the step/load structs.
`default_nettype none

module mfdu_unwrap (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mfdu_pkg::unwrap_step_t              step,
  input  wire mfdu_pkg::unwrap_load_t              load,
  input  wire logic [11:0]                         speed_deadband,
  output logic signed [mfdu_pkg::COUNT_W-1:0]      count_next
);

  logic [mfdu_pkg::POS_W-1:0]          last_position;
  logic signed [mfdu_pkg::COUNT_W-1:0] multi_turn_position;

  logic signed [mfdu_pkg::DELTA_W-1:0] delta;
  logic signed [mfdu_pkg::DELTA_W-1:0] delta_adj;
  logic signed [mfdu_pkg::VEL_W:0]     speed;
  logic [mfdu_pkg::VEL_W:0]            speed_abs;
  logic [mfdu_pkg::VEL_W-1:0]          speed_mag;
  logic                                moving;

  always_comb begin
    delta = $signed({1'b0, step.pos}) - $signed({1'b0, last_position});
    // A step of half a turn or more is taken as a wrap in the other direction.
    if (delta <= -mfdu_pkg::HALF_TURN) begin
      delta_adj = delta + mfdu_pkg::TURN_COUNTS;
    end else if (delta >= mfdu_pkg::HALF_TURN) begin
      delta_adj = delta - mfdu_pkg::TURN_COUNTS;
    end else begin
      delta_adj = delta;
    end

    speed     = $signed({step.vel, 1'b0}) - mfdu_pkg::VEL_ZERO_X2;
    speed_abs = speed[mfdu_pkg::VEL_W] ? 13'(-speed) : 13'(speed);
    speed_mag = speed_abs[mfdu_pkg::VEL_W-1:0];
    moving    = speed_mag > speed_deadband;

    if (moving) begin
      count_next = multi_turn_position
                 + {{(mfdu_pkg::COUNT_W-mfdu_pkg::DELTA_W){delta_adj[mfdu_pkg::DELTA_W-1]}},
                    delta_adj};
    end else begin
      count_next = multi_turn_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position       <= mfdu_pkg::INIT_POSITION_RST;
      multi_turn_position <= mfdu_pkg::COUNT_W'(mfdu_pkg::INIT_POSITION_RST);
    end else if (load.en) begin
      last_position       <= load.value;
      multi_turn_position <= mfdu_pkg::COUNT_W'(load.value);
    end else if (step.en) begin
      last_position       <= step.pos;
      multi_turn_position <= count_next;
    end
  end

  // A single sample never moves the count by more than half a turn.
  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    (step.en && !load.en) |=>
      ((multi_turn_position - $past(multi_turn_position)) <= 48'sd32767 &&
       (multi_turn_position - $past(multi_turn_position)) >= -48'sd32768))
    else $error("multi-turn count moved by more than half a turn");

  a_last_tracks: assert property (@(posedge clk) disable iff (rst)
    (step.en && !load.en) |=> last_position == $past(step.pos))
    else $error("last position not updated from the sample");

  a_load_sets: assert property (@(posedge clk) disable iff (rst)
    load.en |=> multi_turn_position == mfdu_pkg::COUNT_W'(last_position))
    else $error("calibration load left count and last position apart");

endmodule

`default_nettype wire

>>> src/motor_feedback_frame_decode_unwrap.sv
// Top level of the motor feedback frame decoder: frame register, match, unpack,
// result register. Depends on mfdu_pkg and mfdu_unwrap.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   frame    | frame_valid / frame_ready  | frame  (mfdu_pkg::frame_t)
//   result   | result_valid / result_ready| result (mfdu_pkg::result_t)
//   cfg      | cfg_write                  | cfg_index, cfg_data
//
// A frame is registered on transfer and decoded into the result register;
// one frame per cycle is sustained while the result side is not stalled.
// Frames that fail the identifier match are dropped in the frame register.
// A stalled result holds the result register, and the frame register holds
// the next frame, so ready falls only when both are full.
// Synchronous reset restores the register defaults and the unwrap state.
`default_nettype none

module motor_feedback_frame_decode_unwrap (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               frame_valid,
  output logic                                    frame_ready,
  input  wire mfdu_pkg::frame_t                   frame,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output mfdu_pkg::result_t                       result,
  input  wire logic                               cfg_write,
  input  wire logic [mfdu_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [mfdu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [10:0] master_id;
  logic [3:0]  motor_num;
  logic [11:0] speed_deadband;

  logic              s1_valid;
  mfdu_pkg::frame_t  s1_frame;
  logic              s1_match;
  logic              s1_advance;
  logic              out_free;
  logic              load_result;

  mfdu_pkg::result_t      result_next;
  mfdu_pkg::unwrap_step_t unwrap_step;
  mfdu_pkg::unwrap_load_t unwrap_load;
  logic signed [mfdu_pkg::COUNT_W-1:0] count_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_id      <= mfdu_pkg::MASTER_ID_RST;
      motor_num      <= mfdu_pkg::MOTOR_NUM_RST;
      speed_deadband <= mfdu_pkg::SPEED_DEADBAND_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        mfdu_pkg::REG_MASTER_ID:      master_id      <= cfg_data[10:0];
        mfdu_pkg::REG_MOTOR_NUM:      motor_num      <= cfg_data[3:0];
        mfdu_pkg::REG_SPEED_DEADBAND: speed_deadband <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign unwrap_load.en    = cfg_write && (cfg_index == mfdu_pkg::REG_INIT_POSITION);
  assign unwrap_load.value = cfg_data[mfdu_pkg::POS_W-1:0];

  // Handshake between the frame register and the result register.
  assign s1_match    = (s1_frame.can_id == master_id)
                    && (s1_frame.frame_payload[3:0] == motor_num);
  assign out_free    = !result_valid || result_ready;
  assign s1_advance  = s1_valid && (!s1_match || out_free);
  assign load_result = s1_valid && s1_match && out_free;
  assign frame_ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_ready) begin
      s1_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      s1_frame <= frame;
    end
  end

  // Field unpack; position is bytes one and two big-endian.
  always_comb begin
    result_next.position_code       = {s1_frame.frame_payload[15:8],
                                       s1_frame.frame_payload[23:16]};
    result_next.velocity_code       = {s1_frame.frame_payload[31:24],
                                       s1_frame.frame_payload[39:36]};
    result_next.torque_code         = {s1_frame.frame_payload[35:32],
                                       s1_frame.frame_payload[47:40]};
    result_next.motor_state         = s1_frame.frame_payload[7:4];
    result_next.fault_flag          = !s1_frame.frame_payload[7];
    result_next.driver_temp         = s1_frame.frame_payload[55:48];
    result_next.rotor_temp          = s1_frame.frame_payload[63:56];
    result_next.turn_count_position = count_next;
  end

  assign unwrap_step.en  = load_result;
  assign unwrap_step.pos = result_next.position_code;
  assign unwrap_step.vel = result_next.velocity_code;

  mfdu_unwrap u_unwrap (
    .clk            (clk),
    .rst            (rst),
    .step           (unwrap_step),
    .load           (unwrap_load),
    .speed_deadband (speed_deadband),
    .count_next     (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= load_result;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result <= result_next;
    end
  end

  // A frame that fails the match never produces a result.
  a_drop_mismatch: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_match && !result_valid) |=> !result_valid)
    else $error("mismatched frame produced a result");

  a_fault_state: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.fault_flag == !result.motor_state[3]))
    else $error("fault flag disagrees with motor state");

  a_ready_when_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_match) |-> frame_ready)
    else $error("frame stalled behind a frame that is being dropped");

endmodule

`default_nettype wire
